@@ hdl/gtar_pkg.sv @@
package gtar_pkg;

    localparam int MAX_TRACKS         = 64;
    localparam int MAX_MEAS_PER_TRACK = 32;
    localparam int MAX_UNIQUE_MEAS    = 1024;

    localparam int TRK_W     = $clog2(MAX_TRACKS);
    localparam int NUM_W     = $clog2(MAX_TRACKS + 1);
    localparam int SLOT_W    = (MAX_MEAS_PER_TRACK > 1) ? $clog2(MAX_MEAS_PER_TRACK) : 1;
    localparam int CNT_W     = $clog2(MAX_MEAS_PER_TRACK + 1);
    localparam int MADDR_W   = TRK_W + SLOT_W;
    localparam int UIDX_W    = $clog2(MAX_UNIQUE_MEAS);
    localparam int LU_W      = $clog2(MAX_UNIQUE_MEAS + 1);
    localparam int PVAL_W    = 16;
    localparam int ID_W      = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_IDX_W = 6;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_MEAS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SHARED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 2'd2;

    typedef struct packed {
        logic              meas_wr;
        logic              track_close;
        logic              track_ok;
        logic              set_close;
        logic              overflow;
        logic [TRK_W-1:0]  track;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   meas_id;
        logic [PVAL_W-1:0] pval;
        logic [CNT_W-1:0]  meas_count;
        logic [NUM_W-1:0]  num_tracks;
    } cmd_t;

    typedef struct packed {
        logic [PVAL_W-1:0] pval;
        logic [CNT_W-1:0]  meas_count;
        logic [CNT_W-1:0]  shared_count;
    } track_rec_t;

    typedef struct packed {
        logic [MAX_TRACKS-1:0] mask;
        logic [NUM_W-1:0]      count;
    } uentry_t;

    typedef struct packed {
        logic             present;
        logic [UIDX_W-1:0] index;
    } uref_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_BT_RD,
        S_BT_REC,
        S_BM_RD,
        S_BM_ID,
        S_BS_RD,
        S_BS_CMP,
        S_BF_MASK,
        S_BINS,
        S_ST_RD,
        S_ST_REC,
        S_SU_RD,
        S_SU_IDX,
        S_SU_CNT,
        S_W_INIT,
        S_W_RD,
        S_W_CMP,
        S_W_DEC,
        S_R_REC,
        S_R_RD,
        S_R_IDX,
        S_R_MASK,
        S_O_REC,
        S_O_RD,
        S_O_CMP,
        S_OUT
    } state_t;

endpackage

@@ hdl/gtar_front.sv @@
module gtar_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [gtar_pkg::PVAL_W-1:0] in_pval,
    input  logic [gtar_pkg::ID_W-1:0]   in_meas_id,
    input  logic                       in_has_meas,
    input  logic                       in_last_track,
    input  logic                       in_last_set,
    input  logic [5:0]                 min_meas,
    input  logic                       cmd_full,
    output logic                       cmd_push,
    output gtar_pkg::cmd_t             cmd
);

    logic [gtar_pkg::NUM_W-1:0]  loaded_reg, loaded_next;
    logic                        open_reg, open_next;
    logic [gtar_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [gtar_pkg::PVAL_W-1:0] pval_reg, pval_next;
    logic                        ovf_reg, ovf_next;

    logic                        accept;
    logic                        room;
    logic                        close;
    logic [gtar_pkg::CNT_W-1:0]  cnt_eff;
    logic [gtar_pkg::CNT_W-1:0]  cnt_new;
    logic [gtar_pkg::PVAL_W-1:0] pval_eff;
    logic [gtar_pkg::NUM_W-1:0]  loaded_new;
    logic                        ovf_new;

    assign in_ready = !cmd_full;
    assign accept   = in_valid && !cmd_full;
    assign room     = loaded_reg < gtar_pkg::NUM_W'(gtar_pkg::MAX_TRACKS);
    assign close    = in_last_track || in_last_set;
    assign cnt_eff  = open_reg ? cnt_reg : '0;
    assign pval_eff = open_reg ? pval_reg : in_pval;

    always_comb
    begin
        cmd        = '0;
        cnt_new    = cnt_eff;
        loaded_new = loaded_reg;
        ovf_new    = ovf_reg;
        if (room)
        begin
            if (in_has_meas)
            begin
                if (cnt_eff < gtar_pkg::CNT_W'(gtar_pkg::MAX_MEAS_PER_TRACK))
                begin
                    cmd.meas_wr = 1'b1;
                    cnt_new     = cnt_eff + 1'b1;
                end
                else
                begin
                    ovf_new = 1'b1;
                end
            end
            cmd.track_close = close;
            cmd.track_ok    = 32'(cnt_new) >= 32'(min_meas);
            if (close)
            begin
                loaded_new = loaded_reg + 1'b1;
            end
        end
        else
        begin
            ovf_new = 1'b1;
        end
        cmd.track      = loaded_reg[gtar_pkg::TRK_W-1:0];
        cmd.slot       = cnt_eff[gtar_pkg::SLOT_W-1:0];
        cmd.meas_id    = in_meas_id;
        cmd.pval       = pval_eff;
        cmd.meas_count = cnt_new;
        cmd.set_close  = in_last_set;
        cmd.overflow   = ovf_new;
        cmd.num_tracks = loaded_new;
        cmd_push = accept && (cmd.meas_wr || cmd.track_close || cmd.set_close);
    end

    always_comb
    begin
        loaded_next = loaded_reg;
        open_next   = open_reg;
        cnt_next    = cnt_reg;
        pval_next   = pval_reg;
        ovf_next    = ovf_reg;
        if (accept)
        begin
            if (in_last_set)
            begin
                loaded_next = '0;
                open_next   = 1'b0;
                ovf_next    = 1'b0;
            end
            else
            begin
                loaded_next = loaded_new;
                ovf_next    = ovf_new;
                if (room)
                begin
                    open_next = !close;
                    cnt_next  = cnt_new;
                    pval_next = pval_eff;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= '0;
            open_reg   <= 1'b0;
            ovf_reg    <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            loaded_reg <= loaded_next;
            open_reg   <= open_next;
            ovf_reg    <= ovf_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pval_reg <= pval_next;
    end

endmodule

@@ hdl/gtar_cmd_fifo.sv @@
module gtar_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  gtar_pkg::cmd_t din,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output gtar_pkg::cmd_t dout
);

    gtar_pkg::cmd_t entry_reg [gtar_pkg::FIFO_DEPTH];

    logic [gtar_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [gtar_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [gtar_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full    = count_reg == gtar_pkg::FIFO_CNT_W'(gtar_pkg::FIFO_DEPTH);
    assign valid   = count_reg != '0;
    assign dout    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

@@ hdl/gtar_resolver.sv @@
module gtar_resolver (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    input  gtar_pkg::cmd_t             cmd,
    output logic                       cmd_pop,
    input  logic [5:0]                 share_limit,
    input  logic [15:0]                max_iter,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [gtar_pkg::OUT_IDX_W-1:0] out_index,
    output logic                       out_accepted,
    output logic                       out_overflow,
    output logic                       out_last
);

    localparam int MEAS_DEPTH = 2 ** gtar_pkg::MADDR_W;

    logic [gtar_pkg::ID_W-1:0] meas_mem  [MEAS_DEPTH];
    gtar_pkg::uref_t           uref_mem  [MEAS_DEPTH];
    gtar_pkg::track_rec_t      rec_mem   [gtar_pkg::MAX_TRACKS];
    logic [gtar_pkg::ID_W-1:0] uid_mem   [gtar_pkg::MAX_UNIQUE_MEAS];
    gtar_pkg::uentry_t         uent_mem  [gtar_pkg::MAX_UNIQUE_MEAS];

    logic [gtar_pkg::ID_W-1:0] meas_rdata;
    gtar_pkg::uref_t           uref_rdata;
    gtar_pkg::track_rec_t      rec_rdata;
    logic [gtar_pkg::ID_W-1:0] uid_rdata;
    gtar_pkg::uentry_t         uent_rdata;

    logic [gtar_pkg::MADDR_W-1:0] meas_raddr, uref_raddr, meas_waddr, uref_waddr;
    logic [gtar_pkg::TRK_W-1:0]   rec_raddr, rec_waddr;
    logic [gtar_pkg::UIDX_W-1:0]  uid_raddr, uent_raddr, uid_waddr, uent_waddr;
    logic                         meas_we, uref_we, rec_we, uid_we, uent_we;
    logic [gtar_pkg::ID_W-1:0]    meas_wdata, uid_wdata;
    gtar_pkg::uref_t              uref_wdata;
    gtar_pkg::track_rec_t         rec_wdata;
    gtar_pkg::uentry_t            uent_wdata;

    gtar_pkg::state_t state_reg, state_next;

    logic [gtar_pkg::NUM_W-1:0]      n_reg, n_next;
    logic                            ovf_reg, ovf_next;
    logic [gtar_pkg::NUM_W-1:0]      t_reg, t_next;
    logic [gtar_pkg::CNT_W-1:0]      j_reg, j_next;
    logic [gtar_pkg::CNT_W-1:0]      p_reg, p_next;
    logic [gtar_pkg::LU_W-1:0]       k_reg, k_next;
    logic [gtar_pkg::LU_W-1:0]       lu_reg, lu_next;
    logic [gtar_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [gtar_pkg::ID_W-1:0]       id_reg, id_next;
    logic [gtar_pkg::MAX_TRACKS-1:0] alive_reg, alive_next;
    logic [15:0]                     iter_reg, iter_next;
    logic                            any_reg, any_next;
    logic [gtar_pkg::CNT_W-1:0]      top_reg, top_next;
    logic [gtar_pkg::TRK_W-1:0]      w_reg, w_next;
    gtar_pkg::track_rec_t            wrec_reg, wrec_next;
    gtar_pkg::track_rec_t            rec_reg, rec_next;
    logic [gtar_pkg::CNT_W-1:0]      sh_reg, sh_next;
    logic [gtar_pkg::TRK_W-1:0]      owner_reg, owner_next;
    gtar_pkg::track_rec_t            orec_reg, orec_next;
    logic [gtar_pkg::CNT_W-1:0]      c_reg, c_next;

    logic                            out_valid_reg, out_valid_next;
    logic [gtar_pkg::OUT_IDX_W-1:0]  out_index_reg, out_index_next;
    logic                            out_acc_reg, out_acc_next;
    logic                            out_ovf_reg, out_ovf_next;
    logic                            out_last_reg, out_last_next;

    logic [gtar_pkg::TRK_W-1:0]      t_idx;
    logic                            t_done;
    logic                            j_done;
    logic                            p_done;
    logic                            out_load;
    logic                            uniq_full;
    logic                            cand_worse;
    logic [2*gtar_pkg::CNT_W-1:0]    ratio_a, ratio_b;
    logic [gtar_pkg::CNT_W-1:0]      den_a, den_b;
    logic [gtar_pkg::MAX_TRACKS-1:0] rem_mask;
    logic [gtar_pkg::NUM_W-1:0]      rem_count;
    logic [gtar_pkg::TRK_W-1:0]      rem_owner;
    logic                            stop_iter;

    function automatic logic [gtar_pkg::TRK_W-1:0] lowest_set(
        input logic [gtar_pkg::MAX_TRACKS-1:0] mask
    );
        logic [gtar_pkg::TRK_W-1:0] pos;
        pos = '0;
        for (int i = gtar_pkg::MAX_TRACKS - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                pos = gtar_pkg::TRK_W'(i);
            end
        end
        return pos;
    endfunction

    assign t_idx     = t_reg[gtar_pkg::TRK_W-1:0];
    assign t_done    = t_reg == n_reg;
    assign j_done    = j_reg == cnt_reg;
    assign p_done    = p_reg == orec_reg.meas_count;
    assign out_load  = (state_reg == gtar_pkg::S_OUT) && (!out_valid_reg || out_ready);
    assign uniq_full = lu_reg == gtar_pkg::LU_W'(gtar_pkg::MAX_UNIQUE_MEAS);
    assign cmd_pop   = (state_reg == gtar_pkg::S_IDLE) && cmd_valid;
    assign stop_iter = !any_reg || (32'(top_reg) < 32'(share_limit));

    assign den_a   = (rec_rdata.meas_count == '0) ? gtar_pkg::CNT_W'(1) : rec_rdata.meas_count;
    assign den_b   = (wrec_reg.meas_count == '0) ? gtar_pkg::CNT_W'(1) : wrec_reg.meas_count;
    assign ratio_a = rec_rdata.shared_count * den_b;
    assign ratio_b = wrec_reg.shared_count * den_a;
    // Later candidates win a full tie, so equal p-values count as worse.
    assign cand_worse = (ratio_a > ratio_b)
                     || ((ratio_a == ratio_b) && (rec_rdata.pval <= wrec_reg.pval));

    assign rem_mask  = uent_rdata.mask & ~(gtar_pkg::MAX_TRACKS'(1) << w_reg);
    assign rem_count = uent_rdata.count - 1'b1;
    assign rem_owner = lowest_set(rem_mask);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gtar_pkg::S_IDLE:
            begin
                if (cmd_valid && cmd.set_close && (cmd.num_tracks != '0))
                begin
                    state_next = gtar_pkg::S_BT_RD;
                end
            end
            gtar_pkg::S_BT_RD:
            begin
                if (t_done)
                begin
                    state_next = gtar_pkg::S_ST_RD;
                end
                else if (alive_reg[t_idx])
                begin
                    state_next = gtar_pkg::S_BT_REC;
                end
            end
            gtar_pkg::S_BT_REC:  state_next = gtar_pkg::S_BM_RD;
            gtar_pkg::S_BM_RD:   state_next = j_done ? gtar_pkg::S_BT_RD : gtar_pkg::S_BM_ID;
            gtar_pkg::S_BM_ID:   state_next = gtar_pkg::S_BS_RD;
            gtar_pkg::S_BS_RD:   state_next = (k_reg == lu_reg) ? gtar_pkg::S_BINS
                                                               : gtar_pkg::S_BS_CMP;
            gtar_pkg::S_BS_CMP:  state_next = (uid_rdata == id_reg) ? gtar_pkg::S_BF_MASK
                                                                    : gtar_pkg::S_BS_RD;
            gtar_pkg::S_BF_MASK: state_next = gtar_pkg::S_BM_RD;
            gtar_pkg::S_BINS:    state_next = gtar_pkg::S_BM_RD;
            gtar_pkg::S_ST_RD:
            begin
                if (t_done)
                begin
                    state_next = gtar_pkg::S_W_INIT;
                end
                else if (alive_reg[t_idx])
                begin
                    state_next = gtar_pkg::S_ST_REC;
                end
            end
            gtar_pkg::S_ST_REC:  state_next = gtar_pkg::S_SU_RD;
            gtar_pkg::S_SU_RD:   state_next = j_done ? gtar_pkg::S_ST_RD : gtar_pkg::S_SU_IDX;
            gtar_pkg::S_SU_IDX:  state_next = uref_rdata.present ? gtar_pkg::S_SU_CNT
                                                                 : gtar_pkg::S_SU_RD;
            gtar_pkg::S_SU_CNT:  state_next = gtar_pkg::S_SU_RD;
            gtar_pkg::S_W_INIT:  state_next = (iter_reg < max_iter) ? gtar_pkg::S_W_RD
                                                                    : gtar_pkg::S_OUT;
            gtar_pkg::S_W_RD:
            begin
                if (t_done)
                begin
                    state_next = gtar_pkg::S_W_DEC;
                end
                else if (alive_reg[t_idx])
                begin
                    state_next = gtar_pkg::S_W_CMP;
                end
            end
            gtar_pkg::S_W_CMP:   state_next = gtar_pkg::S_W_RD;
            gtar_pkg::S_W_DEC:   state_next = stop_iter ? gtar_pkg::S_OUT : gtar_pkg::S_R_REC;
            gtar_pkg::S_R_REC:   state_next = gtar_pkg::S_R_RD;
            gtar_pkg::S_R_RD:    state_next = j_done ? gtar_pkg::S_W_INIT : gtar_pkg::S_R_IDX;
            gtar_pkg::S_R_IDX:   state_next = uref_rdata.present ? gtar_pkg::S_R_MASK
                                                                 : gtar_pkg::S_R_RD;
            gtar_pkg::S_R_MASK:
            begin
                if (uent_rdata.mask[w_reg] && (rem_count == gtar_pkg::NUM_W'(1)))
                begin
                    state_next = gtar_pkg::S_O_REC;
                end
                else
                begin
                    state_next = gtar_pkg::S_R_RD;
                end
            end
            gtar_pkg::S_O_REC:   state_next = gtar_pkg::S_O_RD;
            gtar_pkg::S_O_RD:    state_next = p_done ? gtar_pkg::S_R_RD : gtar_pkg::S_O_CMP;
            gtar_pkg::S_O_CMP:   state_next = gtar_pkg::S_O_RD;
            gtar_pkg::S_OUT:
            begin
                if (out_load && (t_reg == n_reg - 1'b1))
                begin
                    state_next = gtar_pkg::S_IDLE;
                end
            end
            default:             state_next = gtar_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        n_next     = n_reg;
        ovf_next   = ovf_reg;
        t_next     = t_reg;
        j_next     = j_reg;
        p_next     = p_reg;
        k_next     = k_reg;
        lu_next    = lu_reg;
        cnt_next   = cnt_reg;
        id_next    = id_reg;
        alive_next = alive_reg;
        iter_next  = iter_reg;
        any_next   = any_reg;
        top_next   = top_reg;
        w_next     = w_reg;
        wrec_next  = wrec_reg;
        rec_next   = rec_reg;
        sh_next    = sh_reg;
        owner_next = owner_reg;
        orec_next  = orec_reg;
        c_next     = c_reg;

        out_valid_next = out_valid_reg && !out_ready;
        out_index_next = out_index_reg;
        out_acc_next   = out_acc_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;

        meas_raddr = {t_idx, j_reg[gtar_pkg::SLOT_W-1:0]};
        uref_raddr = {t_idx, j_reg[gtar_pkg::SLOT_W-1:0]};
        rec_raddr  = t_idx;
        uid_raddr  = k_reg[gtar_pkg::UIDX_W-1:0];
        uent_raddr = k_reg[gtar_pkg::UIDX_W-1:0];

        meas_we    = 1'b0;
        meas_waddr = {cmd.track, cmd.slot};
        meas_wdata = cmd.meas_id;
        uref_we    = 1'b0;
        uref_waddr = {t_idx, j_reg[gtar_pkg::SLOT_W-1:0]};
        uref_wdata = '0;
        rec_we     = 1'b0;
        rec_waddr  = cmd.track;
        rec_wdata  = '{pval: cmd.pval, meas_count: cmd.meas_count, shared_count: '0};
        uid_we     = 1'b0;
        uid_waddr  = lu_reg[gtar_pkg::UIDX_W-1:0];
        uid_wdata  = id_reg;
        uent_we    = 1'b0;
        uent_waddr = k_reg[gtar_pkg::UIDX_W-1:0];
        uent_wdata = '0;

        unique case (state_reg)
            gtar_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    meas_we = cmd.meas_wr;
                    if (cmd.track_close)
                    begin
                        rec_we                 = 1'b1;
                        alive_next[cmd.track]  = cmd.track_ok;
                    end
                    if (cmd.set_close)
                    begin
                        n_next    = cmd.num_tracks;
                        ovf_next  = cmd.overflow;
                        lu_next   = '0;
                        iter_next = '0;
                        t_next    = '0;
                    end
                end
            end
            gtar_pkg::S_BT_RD:
            begin
                if (t_done)
                begin
                    t_next = '0;
                end
                else if (!alive_reg[t_idx])
                begin
                    t_next = t_reg + 1'b1;
                end
            end
            gtar_pkg::S_BT_REC:
            begin
                cnt_next = rec_rdata.meas_count;
                j_next   = '0;
            end
            gtar_pkg::S_BM_RD:
            begin
                if (j_done)
                begin
                    t_next = t_reg + 1'b1;
                end
                k_next = '0;
            end
            gtar_pkg::S_BM_ID:
            begin
                id_next = meas_rdata;
            end
            gtar_pkg::S_BS_RD:
            begin
            end
            gtar_pkg::S_BS_CMP:
            begin
                if (uid_rdata != id_reg)
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            gtar_pkg::S_BF_MASK:
            begin
                uent_we          = 1'b1;
                uent_wdata.mask  = uent_rdata.mask | (gtar_pkg::MAX_TRACKS'(1) << t_idx);
                uent_wdata.count = uent_rdata.count
                                 + gtar_pkg::NUM_W'(!uent_rdata.mask[t_idx]);
                uref_we          = 1'b1;
                uref_wdata       = '{present: 1'b1, index: k_reg[gtar_pkg::UIDX_W-1:0]};
                j_next           = j_reg + 1'b1;
            end
            gtar_pkg::S_BINS:
            begin
                uref_we = 1'b1;
                if (uniq_full)
                begin
                    ovf_next   = 1'b1;
                    uref_wdata = '0;
                end
                else
                begin
                    uid_we           = 1'b1;
                    uent_we          = 1'b1;
                    uent_waddr       = lu_reg[gtar_pkg::UIDX_W-1:0];
                    uent_wdata.mask  = gtar_pkg::MAX_TRACKS'(1) << t_idx;
                    uent_wdata.count = gtar_pkg::NUM_W'(1);
                    uref_wdata       = '{present: 1'b1, index: lu_reg[gtar_pkg::UIDX_W-1:0]};
                    lu_next          = lu_reg + 1'b1;
                end
                j_next = j_reg + 1'b1;
            end
            gtar_pkg::S_ST_RD:
            begin
                if (t_done)
                begin
                    t_next = t_reg;
                end
                else if (!alive_reg[t_idx])
                begin
                    t_next = t_reg + 1'b1;
                end
            end
            gtar_pkg::S_ST_REC:
            begin
                rec_next = rec_rdata;
                cnt_next = rec_rdata.meas_count;
                j_next   = '0;
                sh_next  = '0;
            end
            gtar_pkg::S_SU_RD:
            begin
                if (j_done)
                begin
                    rec_we    = 1'b1;
                    rec_waddr = t_idx;
                    rec_wdata = '{pval: rec_reg.pval, meas_count: rec_reg.meas_count,
                                  shared_count: sh_reg};
                    t_next    = t_reg + 1'b1;
                end
            end
            gtar_pkg::S_SU_IDX:
            begin
                uent_raddr = uref_rdata.index;
                if (!uref_rdata.present)
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            gtar_pkg::S_SU_CNT:
            begin
                if (uent_rdata.count > gtar_pkg::NUM_W'(1))
                begin
                    sh_next = sh_reg + 1'b1;
                end
                j_next = j_reg + 1'b1;
            end
            gtar_pkg::S_W_INIT:
            begin
                t_next   = '0;
                any_next = 1'b0;
                top_next = '0;
            end
            gtar_pkg::S_W_RD:
            begin
                if (!t_done && !alive_reg[t_idx])
                begin
                    t_next = t_reg + 1'b1;
                end
            end
            gtar_pkg::S_W_CMP:
            begin
                if (rec_rdata.shared_count > top_reg)
                begin
                    top_next = rec_rdata.shared_count;
                end
                if (!any_reg || cand_worse)
                begin
                    w_next    = t_idx;
                    wrec_next = rec_rdata;
                end
                any_next = 1'b1;
                t_next   = t_reg + 1'b1;
            end
            gtar_pkg::S_W_DEC:
            begin
                rec_raddr = w_reg;
                if (stop_iter)
                begin
                    t_next = '0;
                end
                else
                begin
                    alive_next[w_reg] = 1'b0;
                    iter_next         = iter_reg + 1'b1;
                end
            end
            gtar_pkg::S_R_REC:
            begin
                cnt_next = rec_rdata.meas_count;
                j_next   = '0;
            end
            gtar_pkg::S_R_RD:
            begin
                uref_raddr = {w_reg, j_reg[gtar_pkg::SLOT_W-1:0]};
                if (j_done)
                begin
                    t_next = '0;
                end
            end
            gtar_pkg::S_R_IDX:
            begin
                uent_raddr = uref_rdata.index;
                k_next     = gtar_pkg::LU_W'(uref_rdata.index);
                if (!uref_rdata.present)
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            gtar_pkg::S_R_MASK:
            begin
                rec_raddr  = rem_owner;
                owner_next = rem_owner;
                if (uent_rdata.mask[w_reg])
                begin
                    uent_we          = 1'b1;
                    uent_wdata.mask  = rem_mask;
                    uent_wdata.count = rem_count;
                end
                if (!(uent_rdata.mask[w_reg] && (rem_count == gtar_pkg::NUM_W'(1))))
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            gtar_pkg::S_O_REC:
            begin
                orec_next = rec_rdata;
                p_next    = '0;
                c_next    = '0;
            end
            gtar_pkg::S_O_RD:
            begin
                uref_raddr = {owner_reg, p_reg[gtar_pkg::SLOT_W-1:0]};
                if (p_done)
                begin
                    rec_we    = 1'b1;
                    rec_waddr = owner_reg;
                    rec_wdata = '{pval: orec_reg.pval, meas_count: orec_reg.meas_count,
                                  shared_count: (orec_reg.shared_count > c_reg)
                                              ? orec_reg.shared_count - c_reg : '0};
                    j_next    = j_reg + 1'b1;
                end
            end
            gtar_pkg::S_O_CMP:
            begin
                if (uref_rdata.present
                    && (uref_rdata.index == k_reg[gtar_pkg::UIDX_W-1:0]))
                begin
                    c_next = c_reg + 1'b1;
                end
                p_next = p_reg + 1'b1;
            end
            gtar_pkg::S_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = gtar_pkg::OUT_IDX_W'(t_reg);
                    out_acc_next   = alive_reg[t_idx];
                    out_ovf_next   = ovf_reg;
                    out_last_next  = t_reg == n_reg - 1'b1;
                    t_next         = t_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gtar_pkg::S_IDLE;
            n_reg         <= '0;
            ovf_reg       <= 1'b0;
            t_reg         <= '0;
            j_reg         <= '0;
            p_reg         <= '0;
            k_reg         <= '0;
            lu_reg        <= '0;
            cnt_reg       <= '0;
            alive_reg     <= '0;
            iter_reg      <= '0;
            any_reg       <= 1'b0;
            top_reg       <= '0;
            sh_reg        <= '0;
            c_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            ovf_reg       <= ovf_next;
            t_reg         <= t_next;
            j_reg         <= j_next;
            p_reg         <= p_next;
            k_reg         <= k_next;
            lu_reg        <= lu_next;
            cnt_reg       <= cnt_next;
            alive_reg     <= alive_next;
            iter_reg      <= iter_next;
            any_reg       <= any_next;
            top_reg       <= top_next;
            sh_reg        <= sh_next;
            c_reg         <= c_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg        <= id_next;
        w_reg         <= w_next;
        wrec_reg      <= wrec_next;
        rec_reg       <= rec_next;
        owner_reg     <= owner_next;
        orec_reg      <= orec_next;
        out_index_reg <= out_index_next;
        out_acc_reg   <= out_acc_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (meas_we)
        begin
            meas_mem[meas_waddr] <= meas_wdata;
        end
        meas_rdata <= meas_mem[meas_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (uref_we)
        begin
            uref_mem[uref_waddr] <= uref_wdata;
        end
        uref_rdata <= uref_mem[uref_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[rec_waddr] <= rec_wdata;
        end
        rec_rdata <= rec_mem[rec_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (uid_we)
        begin
            uid_mem[uid_waddr] <= uid_wdata;
        end
        uid_rdata <= uid_mem[uid_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (uent_we)
        begin
            uent_mem[uent_waddr] <= uent_wdata;
        end
        uent_rdata <= uent_mem[uent_raddr];
    end

    assign out_valid    = out_valid_reg;
    assign out_index    = out_index_reg;
    assign out_accepted = out_acc_reg;
    assign out_overflow = out_ovf_reg;
    assign out_last     = out_last_reg;

`ifndef SYNTHESIS
    a_unique_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lu_reg <= gtar_pkg::LU_W'(gtar_pkg::MAX_UNIQUE_MEAS))
        else $error("unique table fill count exceeds capacity");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == gtar_pkg::S_IDLE))
        else $error("command taken outside idle state");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (t_reg == n_reg - 1'b1)) |=> (state_reg == gtar_pkg::S_IDLE))
        else $error("result phase did not end after last track");

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gtar_pkg::S_R_REC) |-> (iter_reg <= max_iter))
        else $error("removal count exceeds limit");
`endif

endmodule

@@ hdl/greedy_track_ambiguity_resolver.sv @@
// Greedy track ambiguity resolver.
// Input stream: one transaction per measurement item. s_tlast closes the
// current track and s_tuser closes the whole track set. Items are taken at
// one per cycle while the queue has room, into a four-entry command queue
// and loaded into the measurement store as the resolver drains it.
// Closing a set starts resolution: a unique-measurement table is built by a
// serial search of the table for each measurement, shared counts are
// formed, and each removal scans all loaded tracks once, comparing the
// surviving ones, then walks the removed track's measurements.
// Resolution time therefore grows with tracks times measurements times
// unique entries; items of the next set queue up and stall once the queue
// is full.
// Output stream: one transaction per loaded track in load order, m_tlast on
// the last one. A stalled receiver holds the output register and pauses the
// resolver; a set with no tracks yields no transactions.
// Reset clears all set state and restores the register defaults; the user
// writes the configuration port only while idle, unenforced by the block.
module greedy_track_ambiguity_resolver (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // track_pval [15:0], meas_id [47:16], has_meas [48], zero fill [55:49]
    input  logic [55:0]                   s_tdata,
    input  logic                          s_tlast,
    // last_of_set [0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // track_index [5:0], accepted [6], overflow [7]
    output logic [7:0]                    m_tdata,
    output logic                          m_tlast,
    input  logic                          cfg_wr_en,
    input  logic [gtar_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gtar_pkg::CFG_W-1:0]     cfg_wdata
);

    logic [5:0]  min_meas_reg, min_meas_next;
    logic [5:0]  share_limit_reg, share_limit_next;
    logic [15:0] max_iter_reg, max_iter_next;

    gtar_pkg::cmd_t front_cmd;
    gtar_pkg::cmd_t queue_cmd;
    logic           cmd_push;
    logic           cmd_full;
    logic           cmd_pop;
    logic           cmd_valid;

    logic [gtar_pkg::OUT_IDX_W-1:0] res_index;
    logic                           res_accepted;
    logic                           res_overflow;

    always_comb
    begin
        min_meas_next    = min_meas_reg;
        share_limit_next = share_limit_reg;
        max_iter_next    = max_iter_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                gtar_pkg::REG_MIN_MEAS:   min_meas_next    = cfg_wdata[5:0];
                gtar_pkg::REG_MAX_SHARED: share_limit_next = cfg_wdata[5:0];
                gtar_pkg::REG_MAX_ITER:   max_iter_next    = cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_meas_reg    <= 6'd3;
            share_limit_reg <= 6'd1;
            max_iter_reg    <= 16'hFFFF;
        end
        else
        begin
            min_meas_reg    <= min_meas_next;
            share_limit_reg <= share_limit_next;
            max_iter_reg    <= max_iter_next;
        end
    end

    gtar_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_pval       (s_tdata[15:0]),
        .in_meas_id    (s_tdata[47:16]),
        .in_has_meas   (s_tdata[48]),
        .in_last_track (s_tlast),
        .in_last_set   (s_tuser),
        .min_meas      (min_meas_reg),
        .cmd_full      (cmd_full),
        .cmd_push      (cmd_push),
        .cmd           (front_cmd)
    );

    gtar_cmd_fifo u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (front_cmd),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .valid (cmd_valid),
        .dout  (queue_cmd)
    );

    gtar_resolver u_resolver (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (queue_cmd),
        .cmd_pop      (cmd_pop),
        .share_limit  (share_limit_reg),
        .max_iter     (max_iter_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_index    (res_index),
        .out_accepted (res_accepted),
        .out_overflow (res_overflow),
        .out_last     (m_tlast)
    );

    assign m_tdata = {res_overflow, res_accepted, res_index};

endmodule

@@ bench/resolver_checker.sv @@
module resolver_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        s_tlast,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [gtar_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gtar_pkg::CFG_W-1:0]     cfg_wdata,
    output int          fail_count,
    output int          verdicts_waiting,
    output int          verdicts_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NT = gtar_pkg::MAX_TRACKS;
    localparam int NM = gtar_pkg::MAX_MEAS_PER_TRACK;
    localparam int NU = gtar_pkg::MAX_UNIQUE_MEAS;

    typedef struct {
        logic [5:0] idx;
        logic       acc;
        logic       ovf;
        logic       last;
    } verdict_t;

    verdict_t    verdict_q[$];

    logic [31:0] meas_mem[NT*NM];
    logic [15:0] pval_mem[NT];
    int unsigned meas_cnt[NT];
    int unsigned shared_cnt[NT];
    bit          alive[NT];
    logic [31:0] uniq_id[NU];
    logic [63:0] uniq_mask[NU];
    int unsigned uniq_cnt[NU];
    int unsigned num_loaded;
    int unsigned num_uniq;
    int unsigned removals;
    bit          ovf_flag;
    bit          trk_open;
    int unsigned min_meas;
    int unsigned share_limit;
    int unsigned max_iter;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic int unsigned lookup_id(input logic [31:0] id);
        for (int unsigned k = 0; k < num_uniq; k++)
            if (uniq_id[k] == id)
                return k;
        return NU;
    endfunction

    function automatic int unsigned times_held(input int unsigned t, input logic [31:0] id);
        int unsigned c;
        c = 0;
        for (int unsigned j = 0; j < meas_cnt[t]; j++)
            if (meas_mem[t*NM+j] == id)
                c++;
        return c;
    endfunction

    function automatic bit drops_first(input int unsigned a, input int unsigned b);
        int unsigned da, db, ra, rb;
        da = meas_cnt[a] ? meas_cnt[a] : 1;
        db = meas_cnt[b] ? meas_cnt[b] : 1;
        ra = shared_cnt[a] * db;
        rb = shared_cnt[b] * da;
        if (ra != rb)
            return ra > rb;
        if (pval_mem[a] != pval_mem[b])
            return pval_mem[a] < pval_mem[b];
        return a > b;
    endfunction

    task automatic resolve_set();
        int unsigned n, k, top, w, owner, c;
        bit any, dup;
        logic [31:0] id;
        n = num_loaded;
        removals = 0;
        num_uniq = 0;
        for (int unsigned t = 0; t < n; t++)
        begin
            alive[t] = meas_cnt[t] >= min_meas;
            shared_cnt[t] = 0;
        end
        for (int unsigned t = 0; t < n; t++)
        begin
            if (!alive[t])
                continue;
            for (int unsigned j = 0; j < meas_cnt[t]; j++)
            begin
                id = meas_mem[t*NM+j];
                k = lookup_id(id);
                if (k == NU)
                begin
                    if (num_uniq >= NU)
                    begin
                        ovf_flag = 1;
                        continue;
                    end
                    k = num_uniq++;
                    uniq_id[k] = id;
                    uniq_mask[k] = '0;
                    uniq_cnt[k] = 0;
                end
                if (!uniq_mask[k][t])
                begin
                    uniq_mask[k][t] = 1'b1;
                    uniq_cnt[k]++;
                end
            end
        end
        for (int unsigned t = 0; t < n; t++)
        begin
            if (!alive[t])
                continue;
            for (int unsigned j = 0; j < meas_cnt[t]; j++)
            begin
                k = lookup_id(meas_mem[t*NM+j]);
                if (k != NU && uniq_cnt[k] > 1)
                    shared_cnt[t]++;
            end
        end
        while (removals < max_iter)
        begin
            any = 0;
            top = 0;
            w = 0;
            for (int unsigned t = 0; t < n; t++)
            begin
                if (!alive[t])
                    continue;
                if (shared_cnt[t] > top)
                    top = shared_cnt[t];
                if (!any || drops_first(t, w))
                    w = t;
                any = 1;
            end
            if (!any || top < share_limit)
                break;
            alive[w] = 0;
            removals++;
            for (int unsigned j = 0; j < meas_cnt[w]; j++)
            begin
                id = meas_mem[w*NM+j];
                dup = 0;
                for (int unsigned p = 0; p < j; p++)
                    if (meas_mem[w*NM+p] == id)
                        dup = 1;
                if (dup)
                    continue;
                k = lookup_id(id);
                if (k == NU || !uniq_mask[k][w])
                    continue;
                uniq_mask[k][w] = 1'b0;
                uniq_cnt[k]--;
                if (uniq_cnt[k] != 1)
                    continue;
                owner = 0;
                while (owner < NT && !uniq_mask[k][owner])
                    owner++;
                if (owner >= n)
                    continue;
                c = times_held(owner, id);
                shared_cnt[owner] = shared_cnt[owner] > c ? shared_cnt[owner] - c : 0;
            end
        end
    endtask

    task automatic take_item(input logic [15:0] pval, input logic [31:0] id, input bit has,
                             input bit end_trk, input bit end_set);
        int unsigned t;
        verdict_t v;
        if (num_loaded < NT)
        begin
            t = num_loaded;
            if (!trk_open)
            begin
                pval_mem[t] = pval;
                meas_cnt[t] = 0;
                trk_open = 1;
            end
            if (has)
            begin
                if (meas_cnt[t] < NM)
                begin
                    meas_mem[t*NM+meas_cnt[t]] = id;
                    meas_cnt[t]++;
                end
                else
                    ovf_flag = 1;
            end
            if (end_trk || end_set)
            begin
                trk_open = 0;
                num_loaded++;
            end
        end
        else
            ovf_flag = 1;
        if (!end_set)
            return;
        resolve_set();
        for (int unsigned i = 0; i < num_loaded; i++)
        begin
            v.idx = i[5:0];
            v.acc = alive[i];
            v.ovf = ovf_flag;
            v.last = (i + 1 == num_loaded);
            verdict_q = {verdict_q, v};
        end
        num_loaded = 0;
        num_uniq = 0;
        ovf_flag = 0;
        trk_open = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t v;
        if (!rst_n)
        begin
            verdict_q.delete();
            for (int i = 0; i < NT; i++)
            begin
                meas_cnt[i] = 0;
                shared_cnt[i] = 0;
                alive[i] = 0;
            end
            num_loaded = 0;
            num_uniq = 0;
            removals = 0;
            ovf_flag = 0;
            trk_open = 0;
            min_meas = 3;
            share_limit = 1;
            max_iter = 65535;
            fail_count = 0;
            verdicts_seen = 0;
            verdicts_waiting = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                verdicts_seen++;
                if (verdict_q.size() == 0)
                    report("unexpected transaction, track_index", m_tdata[5:0], -1);
                else
                begin
                    v = verdict_q.pop_front();
                    if (m_tdata[5:0] !== v.idx)
                        report("track_index", m_tdata[5:0], v.idx);
                    if (m_tdata[6] !== v.acc)
                        report("accepted", m_tdata[6], v.acc);
                    if (m_tdata[7] !== v.ovf)
                        report("overflow", m_tdata[7], v.ovf);
                    if (m_tlast !== v.last)
                        report("last", m_tlast, v.last);
                end
            end
            if (s_tvalid && s_tready)
                take_item(s_tdata[15:0], s_tdata[47:16], s_tdata[48], s_tlast, s_tuser);
            if (cfg_wr_en)
            begin
                if (cfg_index == gtar_pkg::REG_MIN_MEAS)
                    min_meas = cfg_wdata[5:0];
                else if (cfg_index == gtar_pkg::REG_MAX_SHARED)
                    share_limit = cfg_wdata[5:0];
                else if (cfg_index == gtar_pkg::REG_MAX_ITER)
                    max_iter = cfg_wdata;
            end
            verdicts_waiting = verdict_q.size();
        end
    end
endmodule

@@ bench/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_ITEMS = 280;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        s_tlast;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [gtar_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [gtar_pkg::CFG_W-1:0]     cfg_wdata;

    int fail_count;
    int verdicts_waiting;
    int verdicts_seen;
    int cycles;
    int items_sent;
    int sets_sent;
    bit calm;

    greedy_track_ambiguity_resolver DUT (.*);

    resolver_checker u_check (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        int run;
        m_tready = 0;
        run = 0;
        forever
        begin
            @(negedge clk);
            if (run > 0)
                run--;
            else if (calm)
                m_tready = 1;
            else if ($urandom_range(0, 3) == 0)
            begin
                m_tready = 0;
                run = $urandom_range(1, 14) - 1;
            end
            else
            begin
                m_tready = 1;
                run = $urandom_range(0, 30);
            end
        end
    end

    task automatic send_item(input logic [15:0] pval, input logic [31:0] id, input bit has,
                             input bit end_trk, input bit end_set);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 14);
            s_tvalid = 0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1;
        s_tdata = {7'd0, has, id, pval};
        s_tlast = end_trk;
        s_tuser = end_set;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        @(negedge clk);
        s_tvalid = 0;
    endtask

    task automatic wait_idle();
        while (verdicts_waiting != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [gtar_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_wr_en = 1;
        cfg_index = idx;
        cfg_wdata = gtar_pkg::CFG_W'(value);
        @(negedge clk);
        cfg_wr_en = 0;
    endtask

    task automatic set_regs(input int mn, input int ms, input int mi);
        wait_idle();
        write_reg(gtar_pkg::REG_MIN_MEAS, mn);
        write_reg(gtar_pkg::REG_MAX_SHARED, ms);
        write_reg(gtar_pkg::REG_MAX_ITER, mi);
    endtask

    function automatic logic [31:0] pick_id(input int span);
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $urandom_range(0, span);
    endfunction

    function automatic logic [15:0] pick_pval();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 1));
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_set(input int ntrk, input int maxm, input int span);
        int m;
        bit open_end;
        logic [15:0] pv;
        open_end = ($urandom_range(0, 4) == 0);
        for (int t = 0; t < ntrk; t++)
        begin
            pv = pick_pval();
            m = $urandom_range(0, maxm);
            if (m == 0)
                send_item(pv, $urandom, 0, 1, t == ntrk - 1);
            else
                for (int j = 0; j < m; j++)
                begin
                    if ($urandom_range(0, 15) == 0)
                        send_item(16'($urandom), $urandom, 0, 0, 0);
                    send_item(j == 0 ? pv : 16'($urandom), pick_id(span), 1,
                              j == m - 1 && !(open_end && t == ntrk - 1),
                              j == m - 1 && t == ntrk - 1);
                end
        end
        sets_sent++;
    endtask

    initial
    begin
        int start;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tlast = 0;
        s_tuser = 0;
        cfg_wr_en = 0;
        cfg_index = gtar_pkg::REG_MIN_MEAS;
        cfg_wdata = '0;
        calm = 0;
        items_sent = 0;
        sets_sent = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Five tracks, four of them sharing ids, with fields at their extremes, default registers.
        send_item(16'h0000, 32'h0000_0000, 1, 0, 0);
        send_item(16'hFFFF, 32'hFFFF_FFFF, 1, 0, 0);
        send_item(16'h1234, 32'h0000_0005, 1, 1, 0);
        send_item(16'hFFFF, 32'h0000_0000, 1, 0, 0);
        send_item(16'h0000, 32'hFFFF_FFFF, 1, 0, 0);
        send_item(16'h0000, 32'h0000_0007, 1, 1, 0);
        send_item(16'h0000, 32'h0000_0000, 1, 0, 0);
        send_item(16'h0000, 32'h0000_0007, 1, 0, 0);
        send_item(16'h0000, 32'h0000_0007, 1, 1, 0);
        send_item(16'h8000, 32'h0, 0, 1, 0);
        send_item(16'h8000, 32'h0000_0005, 1, 0, 1);
        // Full tie between two identical tracks, then the set closes mid-track.
        set_regs(0, 1, 65535);
        send_item(16'h4000, 32'h9, 1, 0, 0);
        send_item(16'h4000, 32'h9, 1, 1, 0);
        send_item(16'h4000, 32'h9, 1, 0, 0);
        send_item(16'h4000, 32'h9, 1, 1, 0);
        send_item(16'h4000, 32'h3, 1, 0, 1);
        // Zero shared limit removes every survivor; then no removals at all.
        set_regs(0, 0, 65535);
        send_item(16'h1, 32'h1, 1, 1, 0);
        send_item(16'h2, 32'h2, 0, 1, 0);
        send_item(16'h3, 32'h3, 1, 1, 1);
        set_regs(0, 0, 0);
        send_item(16'h1, 32'h1, 1, 1, 0);
        send_item(16'h2, 32'h1, 1, 1, 1);

        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            if (items_sent - start > RANDOM_ITEMS * 4 / 5)
                calm = 1;
            case ($urandom_range(0, 11))
                0: set_regs($urandom_range(0, 32), $urandom_range(0, 32), $urandom);
                1: set_regs(32, 32, 1);
                2: set_regs(1, 1, 65535);
                3: set_regs($urandom_range(0, 4), $urandom_range(1, 3), $urandom_range(0, 6));
                default: ;
            endcase
            send_set($urandom_range(1, 6), 6, $urandom_range(1, 12));
            if (sets_sent == 6)
            begin
                // One long track past the measurement capacity.
                set_regs(2, 1, 65535);
                for (int j = 0; j < gtar_pkg::MAX_MEAS_PER_TRACK + 3; j++)
                    send_item(16'h0100, $urandom_range(0, 40), 1, 0, 0);
                send_item(16'h0200, 32'd3, 1, 1, 1);
                sets_sent++;
            end
            if (sets_sent == 12)
            begin
                // More tracks than the capacity; a dropped item closes the set.
                set_regs(1, 1, 65535);
                for (int t = 0; t < gtar_pkg::MAX_TRACKS + 2; t++)
                    send_item(16'($urandom), $urandom_range(0, 20), 1, 1,
                              t == gtar_pkg::MAX_TRACKS + 1);
                sets_sent++;
            end
        end

        calm = 1;
        while (verdicts_waiting != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("Sent %0d items in %0d sets and checked %0d track verdicts,", items_sent,
                 sets_sent + 4, verdicts_seen);
        $display("with register extremes, capacity overflows and random idling on both sides.");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
